// File: rtl/held_note_arpeggiator_top_assert.svh
// assertion macros shared by the checker
`ifndef HELD_NOTE_ARPEGGIATOR_TOP_ASSERT_SVH
`define HELD_NOTE_ARPEGGIATOR_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define HNA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hna check failed");

// next-cycle implication, off during reset
`define HNA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hna check failed");

// next-cycle implication, always on
`define HNA_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hna check failed");

`endif

// File: rtl/hna_pkg.sv
package hna_pkg;

   // sizes
   localparam int MAX_HELD_DEF = 128;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int NOTE_W = 7;
   localparam int NOTE_COUNT = 128;
   localparam int STEP_W = 32;
   localparam int MODE_W = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PAT_W = 3;
   localparam int LEN_W = 7;
   localparam int ROOT_W = 4;
   localparam int CHOICE_W = 4;
   localparam int DIV_W = 8;
   localparam int PC_W = 4;
   localparam int DIST_W = 4;

   // constants
   localparam logic [NOTE_W-1:0] VELOCITY = 7'd100;
   localparam logic [31:0] LCG_MUL = 32'd1664525;
   localparam logic [31:0] LCG_ADD = 32'd1013904223;
   localparam logic [7:0] PC_OFFSET = 8'd120;
   localparam logic [LEN_W-1:0] LEN_RESET = 7'd8;

   // input modes
   localparam logic [MODE_W-1:0] MODE_PRESS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

   // pattern codes
   localparam logic [PAT_W-1:0] PAT_UP = 3'd0;
   localparam logic [PAT_W-1:0] PAT_DOWN = 3'd1;
   localparam logic [PAT_W-1:0] PAT_UPDOWN = 3'd2;
   localparam logic [PAT_W-1:0] PAT_PLAYED = 3'd3;
   localparam logic [PAT_W-1:0] PAT_RANDOM = 3'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ARP_PATTERN = 3'd0,
      CSR_PATTERN_LENGTH = 3'd1,
      CSR_SCALE_ROOT = 3'd2,
      CSR_SCALE_CHOICE = 3'd3,
      CSR_RANDOM_SEED = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_PRESS,
      CMD_RELEASE,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [NOTE_W-1:0] note;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic start;
      logic [STEP_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DIV_W-1:0] rem;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_MOD_LEN,
      ST_LCG,
      ST_MOD_PICK,
      ST_RANK,
      ST_PLAY_RD,
      ST_PLAY_WAIT,
      ST_QUANT,
      ST_OUT
   } back_state_type;

   // twelve-bit pitch class set of each scale
   function automatic logic [11:0] scale_mask(input logic [CHOICE_W-1:0] choice);
      logic [11:0] m;
      unique case (choice)
         4'd0: m = 12'h0FFF;
         4'd1: m = 12'h0AB5;
         4'd2: m = 12'h05AD;
         4'd3: m = 12'h09AD;
         4'd4: m = 12'h06AD;
         4'd5: m = 12'h05AB;
         4'd6: m = 12'h0AD5;
         4'd7: m = 12'h06B5;
         4'd8: m = 12'h056B;
         4'd9: m = 12'h0295;
         default: m = 12'h04A9;
      endcase
      return m;
   endfunction

   // (note + 120 - root) mod 12 by restoring subtracts
   function automatic logic [PC_W-1:0] pitch_class(input logic [NOTE_W-1:0] note,
                                                   input logic [ROOT_W-1:0] root);
      logic [7:0] x;
      x = 8'(note) + PC_OFFSET - 8'(root);
      if (x >= 8'd192) x = x - 8'd192;
      if (x >= 8'd96) x = x - 8'd96;
      if (x >= 8'd48) x = x - 8'd48;
      if (x >= 8'd24) x = x - 8'd24;
      if (x >= 8'd12) x = x - 8'd12;
      return x[PC_W-1:0];
   endfunction

   function automatic logic in_scale(input logic [NOTE_W-1:0] note,
                                     input logic [ROOT_W-1:0] root,
                                     input logic [CHOICE_W-1:0] choice);
      logic [11:0] m;
      logic [PC_W-1:0] pc;
      m = scale_mask(choice);
      pc = pitch_class(note, root);
      return m[pc];
   endfunction

endpackage

// File: rtl/hna_if.sv
// request channel
interface hna_req_if;
   logic valid;
   logic ready;
   logic [hna_pkg::MODE_W-1:0] mode;
   logic [hna_pkg::NOTE_W-1:0] note_number;
   logic [hna_pkg::STEP_W-1:0] step_index;
   modport source(output valid, output mode, output note_number, output step_index,
                  input ready);
   modport sink(input valid, input mode, input note_number, input step_index,
                output ready);
endinterface

// response channel
interface hna_rsp_if;
   logic valid;
   logic ready;
   logic [hna_pkg::NOTE_W-1:0] out_note;
   logic [hna_pkg::NOTE_W-1:0] velocity;
   modport source(output valid, output out_note, output velocity, input ready);
   modport sink(input valid, input out_note, input velocity, output ready);
endinterface

// File: rtl/hna_divider.sv
module hna_divider (
   input logic clock,
   input logic reset,
   input hna_pkg::div_req_type div_req,
   output hna_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(hna_pkg::STEP_W);
   localparam int WIDE_W = hna_pkg::DIV_W + 1;

   logic busy_ff;
   logic done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [hna_pkg::STEP_W-1:0] dividend_ff;
   logic [hna_pkg::DIV_W-1:0] divisor_ff;
   logic [hna_pkg::DIV_W-1:0] rem_ff;
   logic [WIDE_W-1:0] trial;
   logic [WIDE_W-1:0] diff;
   logic [hna_pkg::DIV_W-1:0] rem_in;

   // one restoring step per cycle
   always_comb begin
      trial = {rem_ff, dividend_ff[hna_pkg::STEP_W-1]};
      diff = trial - {1'b0, divisor_ff};
      rem_in = (trial >= {1'b0, divisor_ff}) ? diff[hna_pkg::DIV_W-1:0]
                                             : trial[hna_pkg::DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            dividend_ff <= div_req.dividend;
            divisor_ff <= div_req.divisor;
            rem_ff <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dividend_ff <= {dividend_ff[hna_pkg::STEP_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(hna_pkg::STEP_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.rem = rem_ff;

endmodule

// File: rtl/hna_front.sv
module hna_front (
   hna_req_if.sink req_chan,
   output logic push_valid,
   input logic push_ready,
   output hna_pkg::cmd_type push_cmd
);

   // classify the incoming transaction, drop unknown modes
   always_comb begin
      push_cmd.note = req_chan.note_number;
      push_cmd.step = req_chan.step_index;
      push_cmd.kind = hna_pkg::CMD_PRESS;
      push_valid = 1'b0;
      unique case (req_chan.mode)
         hna_pkg::MODE_PRESS: begin
            push_cmd.kind = hna_pkg::CMD_PRESS;
            push_valid = req_chan.valid;
         end
         hna_pkg::MODE_RELEASE: begin
            push_cmd.kind = hna_pkg::CMD_RELEASE;
            push_valid = req_chan.valid;
         end
         hna_pkg::MODE_TICK: begin
            push_cmd.kind = hna_pkg::CMD_TICK;
            push_valid = req_chan.valid;
         end
         default: push_valid = 1'b0;
      endcase
   end

   assign req_chan.ready = push_ready;

endmodule

// File: rtl/hna_queue.sv
module hna_queue #(
   parameter int DEPTH = hna_pkg::QUEUE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic push_valid,
   output logic push_ready,
   input hna_pkg::cmd_type push_cmd,
   output logic pop_valid,
   input logic pop_ready,
   output hna_pkg::cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   hna_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [FILL_W-1:0] fill_ff;
   logic push;
   logic pop;

   assign push_ready = (fill_ff != FILL_W'(DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) fill_ff <= fill_ff + 1'b1;
         else if (pop && !push) fill_ff <= fill_ff - 1'b1;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// File: rtl/hna_back.sv
module hna_back #(
   parameter int MAX_HELD = hna_pkg::MAX_HELD_DEF
) (
   input logic clock,
   input logic reset,
   input logic csr_we,
   input logic [hna_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [hna_pkg::CSR_DATA_W-1:0] csr_wdata,
   input logic cmd_valid,
   output logic cmd_ready,
   input hna_pkg::cmd_type cmd,
   hna_rsp_if.source rsp_chan
);

   localparam int IDX_W = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
   localparam int CNT_W = $clog2(MAX_HELD + 1);
   localparam int WIDE_W = hna_pkg::DIV_W + 1;
   localparam int NW = hna_pkg::NOTE_W;

   hna_pkg::back_state_type state_ff, state_in;
   hna_pkg::cmd_type cmd_ff;
   logic [CNT_W-1:0] count_ff;
   logic [hna_pkg::NOTE_COUNT-1:0] bitmap_ff;
   logic [IDX_W-1:0] addr_ff;
   logic [31:0] rs_ff;
   logic [hna_pkg::PAT_W-1:0] pattern_ff;
   logic [hna_pkg::LEN_W-1:0] length_ff;
   logic [hna_pkg::ROOT_W-1:0] root_ff;
   logic [hna_pkg::CHOICE_W-1:0] choice_ff;
   logic [IDX_W-1:0] pick_ff;
   logic [NW-1:0] note_ff;
   logic [hna_pkg::DIST_W-1:0] dist_ff;
   logic upper_ff;
   logic [NW-1:0] rank_v_ff;
   logic [IDX_W-1:0] rank_cnt_ff;
   logic [NW-1:0] result_ff;
   logic out_valid_ff;
   logic [NW-1:0] out_note_ff;
   logic [NW-1:0] mem [MAX_HELD];
   logic [NW-1:0] mem_q_ff;

   logic mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [IDX_W-1:0] mem_ra;
   logic [NW-1:0] mem_wd;
   logic out_load;
   logic full;
   logic new_press;
   logic shift_last;
   logic rank_hit;
   logic quant_hit;
   logic cand_ok;
   logic [31:0] lcg_next;
   logic [hna_pkg::DIV_W-1:0] len_div;
   logic [hna_pkg::DIV_W-1:0] n_div;
   logic [hna_pkg::DIV_W-1:0] span;
   logic [WIDE_W-1:0] count_w;
   logic [WIDE_W-1:0] span_w;
   logic [WIDE_W-1:0] rem_w;
   logic [WIDE_W-1:0] pick_calc;
   logic [WIDE_W-1:0] cand_w;
   logic [WIDE_W-1:0] note_w;
   logic [WIDE_W-1:0] dist_w;
   hna_pkg::div_req_type div_req;
   hna_pkg::div_rsp_type div_rsp;

   hna_divider u_divider (
      .clock(clock),
      .reset(reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   // shared arithmetic
   always_comb begin
      full = (count_ff == CNT_W'(MAX_HELD));
      new_press = (cmd.kind == hna_pkg::CMD_PRESS) && !bitmap_ff[cmd.note] && !full;
      shift_last = ((CNT_W'(addr_ff) + 1'b1) >= count_ff);
      lcg_next = rs_ff * hna_pkg::LCG_MUL + hna_pkg::LCG_ADD;
      len_div = (length_ff == '0) ? 8'd1 : hna_pkg::DIV_W'(length_ff);
      n_div = hna_pkg::DIV_W'(count_ff);
      count_w = WIDE_W'(count_ff);
      span_w = {count_w[WIDE_W-2:0], 1'b0} - WIDE_W'(2);
      span = (count_ff == CNT_W'(1)) ? 8'd1 : span_w[hna_pkg::DIV_W-1:0];
      rem_w = WIDE_W'(div_rsp.rem);
      if (pattern_ff == hna_pkg::PAT_DOWN) begin
         pick_calc = count_w - WIDE_W'(1) - rem_w;
      end else if (pattern_ff == hna_pkg::PAT_UPDOWN) begin
         pick_calc = (rem_w < count_w) ? rem_w : (WIDE_W'(span) - rem_w);
      end else begin
         pick_calc = rem_w;
      end
      rank_hit = bitmap_ff[rank_v_ff] && (rank_cnt_ff == pick_ff);
      note_w = WIDE_W'(note_ff);
      dist_w = WIDE_W'(dist_ff);
      cand_w = upper_ff ? (note_w + dist_w) : (note_w - dist_w);
      cand_ok = upper_ff ? (cand_w <= WIDE_W'(hna_pkg::NOTE_COUNT - 1)) : (note_w >= dist_w);
      quant_hit = cand_ok && hna_pkg::in_scale(cand_w[NW-1:0], root_ff, choice_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hna_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  hna_pkg::CMD_RELEASE:
                     state_in = bitmap_ff[cmd.note] ? hna_pkg::ST_FIND_RD : hna_pkg::ST_IDLE;
                  hna_pkg::CMD_TICK:
                     state_in = (count_ff != '0) ? hna_pkg::ST_MOD_LEN : hna_pkg::ST_IDLE;
                  default: state_in = hna_pkg::ST_IDLE;
               endcase
            end
         end
         hna_pkg::ST_FIND_RD: state_in = hna_pkg::ST_FIND_CMP;
         hna_pkg::ST_FIND_CMP:
            state_in = (mem_q_ff == cmd_ff.note) ? hna_pkg::ST_SHIFT_RD : hna_pkg::ST_FIND_RD;
         hna_pkg::ST_SHIFT_RD:
            state_in = shift_last ? hna_pkg::ST_IDLE : hna_pkg::ST_SHIFT_WR;
         hna_pkg::ST_SHIFT_WR: state_in = hna_pkg::ST_SHIFT_RD;
         hna_pkg::ST_MOD_LEN: begin
            if (div_rsp.done) begin
               state_in = (pattern_ff == hna_pkg::PAT_RANDOM) ? hna_pkg::ST_LCG
                                                            : hna_pkg::ST_MOD_PICK;
            end
         end
         hna_pkg::ST_LCG: state_in = hna_pkg::ST_MOD_PICK;
         hna_pkg::ST_MOD_PICK: begin
            if (div_rsp.done) begin
               state_in = (pattern_ff == hna_pkg::PAT_PLAYED) ? hna_pkg::ST_PLAY_RD
                                                            : hna_pkg::ST_RANK;
            end
         end
         hna_pkg::ST_RANK: if (rank_hit) state_in = hna_pkg::ST_QUANT;
         hna_pkg::ST_PLAY_RD: state_in = hna_pkg::ST_PLAY_WAIT;
         hna_pkg::ST_PLAY_WAIT: state_in = hna_pkg::ST_QUANT;
         hna_pkg::ST_QUANT: if (quant_hit) state_in = hna_pkg::ST_OUT;
         hna_pkg::ST_OUT: if (out_load) state_in = hna_pkg::ST_IDLE;
         default: state_in = hna_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_ready = 1'b0;
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = mem_q_ff;
      mem_ra = addr_ff;
      out_load = 1'b0;
      div_req.start = 1'b0;
      div_req.dividend = cmd.step;
      div_req.divisor = len_div;
      unique case (state_ff)
         hna_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid && new_press) begin
               mem_we = 1'b1;
               mem_wa = count_ff[IDX_W-1:0];
               mem_wd = cmd.note;
            end
            if (cmd_valid && (cmd.kind == hna_pkg::CMD_TICK) && (count_ff != '0)) begin
               div_req.start = 1'b1;
            end
         end
         hna_pkg::ST_FIND_RD: mem_ra = addr_ff;
         hna_pkg::ST_SHIFT_RD: mem_ra = IDX_W'(CNT_W'(addr_ff) + 1'b1);
         hna_pkg::ST_SHIFT_WR: begin
            mem_we = 1'b1;
            mem_wa = addr_ff;
            mem_wd = mem_q_ff;
         end
         hna_pkg::ST_MOD_LEN: begin
            if (div_rsp.done && (pattern_ff != hna_pkg::PAT_RANDOM)) begin
               div_req.start = 1'b1;
               div_req.dividend = hna_pkg::STEP_W'(div_rsp.rem);
               div_req.divisor = (pattern_ff == hna_pkg::PAT_UPDOWN) ? span : n_div;
            end
         end
         hna_pkg::ST_LCG: begin
            div_req.start = 1'b1;
            div_req.dividend = lcg_next;
            div_req.divisor = n_div;
         end
         hna_pkg::ST_PLAY_RD: mem_ra = pick_ff;
         hna_pkg::ST_OUT: out_load = !out_valid_ff || rsp_chan.ready;
         default: cmd_ready = 1'b0;
      endcase
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hna_pkg::ST_IDLE;
         count_ff <= '0;
         bitmap_ff <= '0;
         rs_ff <= '0;
         pattern_ff <= hna_pkg::PAT_UP;
         length_ff <= hna_pkg::LEN_RESET;
         root_ff <= '0;
         choice_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            hna_pkg::ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff <= cmd;
                  addr_ff <= '0;
                  if (new_press) begin
                     bitmap_ff[cmd.note] <= 1'b1;
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            hna_pkg::ST_FIND_CMP: if (mem_q_ff != cmd_ff.note) addr_ff <= addr_ff + 1'b1;
            hna_pkg::ST_SHIFT_RD: begin
               if (shift_last) begin
                  count_ff <= count_ff - 1'b1;
                  bitmap_ff[cmd_ff.note] <= 1'b0;
               end
            end
            hna_pkg::ST_SHIFT_WR: addr_ff <= addr_ff + 1'b1;
            hna_pkg::ST_LCG: rs_ff <= lcg_next;
            hna_pkg::ST_MOD_PICK: begin
               if (div_rsp.done) begin
                  pick_ff <= pick_calc[IDX_W-1:0];
                  rank_v_ff <= '0;
                  rank_cnt_ff <= '0;
               end
            end
            hna_pkg::ST_RANK: begin
               rank_v_ff <= rank_v_ff + 1'b1;
               if (bitmap_ff[rank_v_ff] && !rank_hit) rank_cnt_ff <= rank_cnt_ff + 1'b1;
               if (rank_hit) begin
                  note_ff <= rank_v_ff;
                  dist_ff <= '0;
                  upper_ff <= 1'b0;
               end
            end
            hna_pkg::ST_PLAY_WAIT: begin
               note_ff <= mem_q_ff;
               dist_ff <= '0;
               upper_ff <= 1'b0;
            end
            hna_pkg::ST_QUANT: begin
               if (quant_hit) begin
                  result_ff <= cand_w[NW-1:0];
               end else if (upper_ff) begin
                  dist_ff <= dist_ff + 1'b1;
                  upper_ff <= 1'b0;
               end else begin
                  upper_ff <= 1'b1;
               end
            end
            default: ;
         endcase

         // output register
         if (out_load) begin
            out_valid_ff <= 1'b1;
            out_note_ff <= result_ff;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end

         // register writes
         if (csr_we) begin
            unique case (csr_index)
               hna_pkg::CSR_ARP_PATTERN: pattern_ff <= csr_wdata[hna_pkg::PAT_W-1:0];
               hna_pkg::CSR_PATTERN_LENGTH: length_ff <= csr_wdata[hna_pkg::LEN_W-1:0];
               hna_pkg::CSR_SCALE_ROOT: root_ff <= csr_wdata[hna_pkg::ROOT_W-1:0];
               hna_pkg::CSR_SCALE_CHOICE: choice_ff <= csr_wdata[hna_pkg::CHOICE_W-1:0];
               hna_pkg::CSR_RANDOM_SEED: rs_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // held note memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q_ff <= mem[mem_ra];
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.out_note = out_note_ff;
   assign rsp_chan.velocity = hna_pkg::VELOCITY;

endmodule

// File: rtl/held_note_arpeggiator_top.sv
// channel    dir  payload                              handshake
// req_chan   in   mode, note_number, step_index        valid/ready
// rsp_chan   out  out_note, velocity                   valid/ready
// csr_*      in   csr_index, csr_wdata                 csr_we, no stall
//
// press: handled in the idle state of the back end; release: a search for the
// entry, then a shift of the later entries down through the note memory
// tick: two passes through the serial divider (with an LCG step for the random
// pattern), then the rank scan over note values or a played-order read, then the scale search
// reset is synchronous and clears the held list, config and output register
// a 4-entry command queue lets requests arrive while a result waits
module held_note_arpeggiator_top #(
   parameter int MAX_HELD = hna_pkg::MAX_HELD_DEF,
   parameter int QUEUE_DEPTH = hna_pkg::QUEUE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   hna_req_if.sink req_chan,
   hna_rsp_if.source rsp_chan,
   input logic csr_we,
   input logic [hna_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [hna_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic push_valid;
   logic push_ready;
   logic pop_valid;
   logic pop_ready;
   hna_pkg::cmd_type push_cmd;
   hna_pkg::cmd_type pop_cmd;

   hna_front u_front (
      .req_chan(req_chan),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd(push_cmd)
   );

   hna_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd(push_cmd),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_cmd(pop_cmd)
   );

   hna_back #(.MAX_HELD(MAX_HELD)) u_back (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd_valid(pop_valid),
      .cmd_ready(pop_ready),
      .cmd(pop_cmd),
      .rsp_chan(rsp_chan)
   );

endmodule

// File: rtl/hna_checker.sv
`include "held_note_arpeggiator_top_assert.svh"

module hna_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [hna_pkg::NOTE_W-1:0] rsp_out_note,
   input logic [hna_pkg::NOTE_W-1:0] rsp_velocity
);

   // reset leaves no result pending
   `HNA_ASSERT_ALWAYS_NEXT(a_reset_clears, clock, reset, !rsp_valid)

   // a stalled result stays offered with the same payload
   `HNA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_note) && $stable(rsp_velocity))

   // every result carries the fixed velocity
   `HNA_ASSERT_SAME(a_velocity, clock, reset, rsp_valid, rsp_velocity == hna_pkg::VELOCITY)

endmodule

bind held_note_arpeggiator_top hna_checker u_hna_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_out_note(rsp_chan.out_note),
   .rsp_velocity(rsp_chan.velocity)
);
